// ===== rtl/hec_pkg.sv =====
// Shared types, character constants and helpers of the hex escape codec.
`timescale 1ns / 1ps
package hec_pkg;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_USCORE = 8'h5F;

  localparam int unsigned MaxOut = 4;

  typedef enum logic {
    MODE_ESCAPE   = 1'b0,
    MODE_UNESCAPE = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    PEND_NONE  = 2'd0,
    PEND_BSL   = 2'd1,
    PEND_X     = 2'd2,
    PEND_DIGIT = 2'd3
  } pend_e;

  // One accepted item's worth of output bytes.
  typedef struct packed {
    logic [MaxOut-1:0][7:0] data;
    logic [2:0]             cnt;
    logic                   last;
  } desc_t;

  typedef struct packed {
    logic  empty;
    desc_t desc;
  } q_head_t;

  function automatic logic keeps_literal(logic [7:0] b);
    logic r;
    r = (b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]}) ||
        (b == CH_COLON) || (b == CH_USCORE) || (b == CH_DOT);
    return r;
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_val(logic [7:0] b);
    logic [4:0] r;
    r = '0;
    if (b inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    logic [7:0] r;
    if (n < 4'd10) begin
      r = 8'h30 + {4'd0, n};
    end else begin
      r = 8'h57 + {4'd0, n};
    end
    return r;
  endfunction

  function automatic desc_t put(desc_t d, logic [7:0] b);
    desc_t r;
    r = d;
    r.data[r.cnt[1:0]] = b;
    r.cnt = r.cnt + 3'd1;
    return r;
  endfunction

  function automatic desc_t put_escape(desc_t d, logic [7:0] b);
    desc_t r;
    r = put(d, CH_BSL);
    r = put(r, CH_X);
    r = put(r, hex_char(b[7:4]));
    r = put(r, hex_char(b[3:0]));
    return r;
  endfunction

  function automatic desc_t flush_held(desc_t d, pend_e p, logic [7:0] dig);
    desc_t r;
    r = d;
    if (p != PEND_NONE) r = put(r, CH_BSL);
    if (p == PEND_X || p == PEND_DIGIT) r = put(r, CH_X);
    if (p == PEND_DIGIT) r = put(r, dig);
    return r;
  endfunction

endpackage

// ===== rtl/hec_front.sv =====
// Front end: takes input beats, tracks escape state and builds output descriptors.
`timescale 1ns / 1ps
module hec_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  input  logic           cfg_mode_i,
  input  logic           accept_i,
  input  logic [7:0]     in_byte_i,
  input  logic           in_last_i,
  output hec_pkg::desc_t desc_o,
  output logic           wr_o
);
  import hec_pkg::*;

  mode_e      mode_q, mode_d;
  logic       at_start_q, at_start_d;
  pend_e      pend_q, pend_d;
  logic [7:0] dig_q, dig_d;
  desc_t      desc;
  logic       brk, plain;
  logic [4:0] hv, hv_dig;

  always_comb begin
    desc       = '0;
    desc.last  = in_last_i;
    mode_d     = mode_q;
    at_start_d = at_start_q;
    pend_d     = pend_q;
    dig_d      = dig_q;
    brk        = 1'b0;
    plain      = 1'b0;
    hv         = hex_val(in_byte_i);
    hv_dig     = hex_val(dig_q);

    if (mode_q == MODE_ESCAPE) begin
      if (at_start_q && in_byte_i == CH_DOT) begin
        desc = put_escape(desc, in_byte_i);
      end else if (in_byte_i == CH_SLASH) begin
        desc = put(desc, CH_DASH);
      end else if (in_byte_i == CH_DASH || in_byte_i == CH_BSL ||
                   !keeps_literal(in_byte_i)) begin
        desc = put_escape(desc, in_byte_i);
      end else begin
        desc = put(desc, in_byte_i);
      end
    end else begin
      case (pend_q)
        PEND_BSL: begin
          if (in_byte_i == CH_X) pend_d = PEND_X;
          else brk = 1'b1;
        end
        PEND_X: begin
          if (hv[4]) begin
            dig_d  = in_byte_i;
            pend_d = PEND_DIGIT;
          end else begin
            brk = 1'b1;
          end
        end
        PEND_DIGIT: begin
          if (hv[4]) begin
            desc   = put(desc, {hv_dig[3:0], hv[3:0]});
            pend_d = PEND_NONE;
          end else begin
            brk = 1'b1;
          end
        end
        default: plain = 1'b1;
      endcase
      if (brk) begin
        desc   = flush_held(desc, pend_q, dig_q);
        pend_d = PEND_NONE;
        plain  = 1'b1;
      end
      if (plain) begin
        if (in_byte_i == CH_DASH) begin
          desc = put(desc, CH_SLASH);
        end else if (in_byte_i == CH_BSL) begin
          pend_d = PEND_BSL;
        end else begin
          desc = put(desc, in_byte_i);
        end
      end
      if (in_last_i) begin
        desc   = flush_held(desc, pend_d, dig_d);
        pend_d = PEND_NONE;
      end
    end
    at_start_d = in_last_i;

    // mode write abandons the string in progress
    if (cfg_valid_i) begin
      mode_d     = mode_e'(cfg_mode_i);
      at_start_d = 1'b1;
      pend_d     = PEND_NONE;
      dig_d      = dig_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_ESCAPE;
      at_start_q <= 1'b1;
      pend_q     <= PEND_NONE;
      dig_q      <= '0;
    end else if (cfg_valid_i || accept_i) begin
      mode_q     <= mode_d;
      at_start_q <= at_start_d;
      pend_q     <= pend_d;
      dig_q      <= dig_d;
    end
  end

  assign desc_o = desc;
  assign wr_o   = accept_i && !cfg_valid_i && (desc.cnt != 3'd0);

endmodule

// ===== rtl/hec_fifo.sv =====
// Descriptor queue between front and back ends.
`timescale 1ns / 1ps
module hec_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  hec_pkg::desc_t   wdata_i,
  input  logic             rd_i,
  output logic             full_o,
  output hec_pkg::q_head_t head_o
);
  import hec_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastPtr = AW'(Depth - 1);
  localparam logic [CW-1:0] FullCnt = CW'(Depth);

  desc_t         mem_q [Depth];
  logic [AW-1:0] wptr_q, rptr_q;
  logic [CW-1:0] cnt_q;
  logic          do_rd;

  assign do_rd = rd_i && (cnt_q != '0);

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_i) wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + AW'(1);
      if (do_rd) rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + AW'(1);
      if (wr_i && !do_rd) cnt_q <= cnt_q + CW'(1);
      else if (!wr_i && do_rd) cnt_q <= cnt_q - CW'(1);
    end
  end

  assign full_o       = (cnt_q == FullCnt);
  assign head_o.empty = (cnt_q == '0);
  assign head_o.desc  = mem_q[rptr_q];

endmodule

// ===== rtl/hec_back.sv =====
// Back end: walks the head descriptor and hands out one byte per beat.
`timescale 1ns / 1ps
module hec_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hec_pkg::q_head_t head_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [7:0]       out_byte_o,
  output logic             out_last_o,
  output logic             rd_o
);
  import hec_pkg::*;

  logic [1:0] idx_q;
  logic       last_beat, take;

  assign empty_o    = head_i.empty;
  assign take       = pop_i && !head_i.empty;
  assign last_beat  = ({1'b0, idx_q} + 3'd1) == head_i.desc.cnt;
  assign out_byte_o = head_i.desc.data[idx_q];
  assign out_last_o = head_i.desc.last && last_beat;
  assign rd_o       = take && last_beat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (take) begin
      idx_q <= last_beat ? '0 : idx_q + 2'd1;
    end
  end

endmodule

// ===== rtl/hex_escape_codec_core.sv =====
// Top level of the backslash-x hex escape codec.
`timescale 1ns / 1ps
// Converts a byte stream to or from the backslash-x hex escape name form,
// direction set by the mode register (0 escape, 1 unescape). A write to
// mode abandons any string in progress. An input beat is taken every cycle
// while the descriptor queue (QDepth entries) has room; each beat turns
// into zero to four output bytes, and the back end sends one byte per
// cycle while pop is asserted and the queue is not empty. The bytes of
// each beat are written as one descriptor into the queue and leave from its head.
// No clearing pass is needed after reset.
module hex_escape_codec_core #(
  parameter int unsigned QDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_mode_i,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);
  import hec_pkg::*;

  desc_t   desc;
  q_head_t head;
  logic    wr, rd, accept;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  hec_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_mode_i  (cfg_mode_i),
    .accept_i    (accept),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .desc_o      (desc),
    .wr_o        (wr)
  );

  hec_fifo #(
    .Depth (QDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr),
    .wdata_i (desc),
    .rd_i    (rd),
    .full_o  (full),
    .head_o  (head)
  );

  hec_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_byte_o (out_byte_o),
    .out_last_o (out_last_o),
    .rd_o       (rd)
  );

  a_no_wr_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr |-> !full)
    else $error("descriptor written into full queue");

  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_last_i && !cfg_valid_i) |-> wr)
    else $error("last beat produced no output");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr |-> (desc.cnt != 3'd0 && desc.cnt <= 3'd4))
    else $error("descriptor byte count out of range");

  a_head_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head.empty |-> (head.desc.cnt != 3'd0 && head.desc.cnt <= 3'd4))
    else $error("queue head holds an empty descriptor");

endmodule
